FILE: hw/rtl/fdr_pkg.sv
`default_nettype none
package fdr_pkg;

  localparam int VECTOR_FRAC_BITS = 14;
  localparam int WORK_FRAC        = 30;
  localparam int IDX_W            = 15;
  localparam logic [IDX_W-1:0] ONE_IDX   = 15'd4096;
  localparam logic [IDX_W-1:0] IDX_RESET = 15'd6144;

  localparam int SQRT_STEPS = 31;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int SDIV_STEPS = WORK_FRAC;
  localparam int SDIV_LAT   = SDIV_STEPS + 1;
  localparam int RDIV_STEPS = 17;
  localparam int RDIV_LAT   = RDIV_STEPS + 1;

  localparam logic [15:0] REFL_ONE = 16'd32768;

  typedef struct packed {
    logic [30:0]      ci;
    logic [IDX_W-1:0] ei;
    logic [IDX_W-1:0] et;
    logic             tir;
  } side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fdr_sqrt.sv
`default_nettype none
module fdr_sqrt
  import fdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [60:0] in_rad,
  output logic             out_vld,
  output logic [30:0]      out_root
);

  logic [61:0]         v_r   [0:SQRT_STEPS];
  logic [61:0]         res_r [0:SQRT_STEPS];
  logic [SQRT_STEPS:0] vld_r;
  logic [61:0]         v_nxt   [0:SQRT_STEPS-1];
  logic [61:0]         res_nxt [0:SQRT_STEPS-1];

  always_comb begin
    logic [61:0] bitv;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bitv = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
      if (v_r[k] >= res_r[k] + bitv) begin
        v_nxt[k]   = v_r[k] - (res_r[k] + bitv);
        res_nxt[k] = (res_r[k] >> 1) + bitv;
      end else begin
        v_nxt[k]   = v_r[k];
        res_nxt[k] = res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    v_r[0]   <= {1'b0, in_rad};
    res_r[0] <= '0;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      v_r[k+1]   <= v_nxt[k];
      res_r[k+1] <= res_nxt[k];
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS];
  assign out_root = res_r[SQRT_STEPS][30:0];

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_sdiv.sv
`default_nettype none
module fdr_sdiv
  import fdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire logic [45:0]      in_num,
  input  wire logic [IDX_W-1:0] in_den,
  output logic                  out_vld,
  output logic [WORK_FRAC-1:0]  out_quo,
  output logic                  out_ovf
);

  logic [45:0]          rem_r [0:SDIV_STEPS];
  logic [IDX_W-1:0]     den_r [0:SDIV_STEPS];
  logic [WORK_FRAC-1:0] quo_r [0:SDIV_STEPS];
  logic [SDIV_STEPS:0]  ovf_r;
  logic [SDIV_STEPS:0]  vld_r;
  logic [45:0]          rem_nxt [0:SDIV_STEPS-1];
  logic [WORK_FRAC-1:0] quo_nxt [0:SDIV_STEPS-1];

  always_comb begin
    logic [45:0] trial;
    for (int k = 0; k < SDIV_STEPS; k++) begin
      trial = {{(46-IDX_W){1'b0}}, den_r[k]} << (SDIV_STEPS - 1 - k);
      quo_nxt[k] = quo_r[k];
      if (rem_r[k] >= trial) begin
        rem_nxt[k] = rem_r[k] - trial;
        quo_nxt[k][SDIV_STEPS-1-k] = 1'b1;
      end else begin
        rem_nxt[k] = rem_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SDIV_STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    ovf_r[0] <= in_num >= {1'b0, in_den, {WORK_FRAC{1'b0}}};
    for (int k = 0; k < SDIV_STEPS; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      den_r[k+1] <= den_r[k];
      quo_r[k+1] <= quo_nxt[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  assign out_vld = vld_r[SDIV_STEPS];
  assign out_quo = quo_r[SDIV_STEPS];
  assign out_ovf = ovf_r[SDIV_STEPS];

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_rdiv.sv
`default_nettype none
module fdr_rdiv
  import fdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [45:0] in_p,
  input  wire logic [45:0] in_q,
  output logic             out_vld,
  output logic [16:0]      out_ratio
);

  logic [61:0]         rem_r [0:RDIV_STEPS];
  logic [46:0]         den_r [0:RDIV_STEPS];
  logic [16:0]         quo_r [0:RDIV_STEPS];
  logic [RDIV_STEPS:0] zero_r;
  logic [RDIV_STEPS:0] vld_r;
  logic [61:0]         rem_nxt [0:RDIV_STEPS-1];
  logic [16:0]         quo_nxt [0:RDIV_STEPS-1];
  logic [45:0]         num;
  logic [46:0]         den;

  assign num = (in_p > in_q) ? in_p - in_q : in_q - in_p;
  assign den = {1'b0, in_p} + {1'b0, in_q};

  always_comb begin
    logic [62:0] trial;
    for (int k = 0; k < RDIV_STEPS; k++) begin
      trial = {16'b0, den_r[k]} << (RDIV_STEPS - 1 - k);
      quo_nxt[k] = quo_r[k];
      if ({1'b0, rem_r[k]} >= trial) begin
        rem_nxt[k] = rem_r[k] - trial[61:0];
        quo_nxt[k][RDIV_STEPS-1-k] = 1'b1;
      end else begin
        rem_nxt[k] = rem_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RDIV_STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= {num, 16'b0};
    den_r[0]  <= den;
    quo_r[0]  <= '0;
    zero_r[0] <= (den == '0);
    for (int k = 0; k < RDIV_STEPS; k++) begin
      rem_r[k+1]  <= rem_nxt[k];
      den_r[k+1]  <= den_r[k];
      quo_r[k+1]  <= quo_nxt[k];
      zero_r[k+1] <= zero_r[k];
    end
  end

  assign out_vld   = vld_r[RDIV_STEPS];
  assign out_ratio = zero_r[RDIV_STEPS] ? 17'h10000 : quo_r[RDIV_STEPS];

endmodule
`default_nettype wire

FILE: hw/rtl/dielectric_fresnel_reflectance.sv
// Channel        Ports                                   Handshake
// input          in_dir_*, in_norm_*                     start & !busy
// result         out_reflectance, out_total_reflection   out_strobe, one cycle
// configuration  cfg_wdata                               cfg_we
//
// One transaction enters every cycle; busy is always low.
// Each result passes through two 32-stage square roots,
// a 31-stage quotient, an 18-stage ratio divider and eight product/select stages.
// Synchronous active-low reset clears the valid pipeline and loads index 6144.
// The receiver cannot stall; the pipeline advances every cycle.
`default_nettype none
module dielectric_fresnel_reflectance
  import fdr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic signed [15:0] in_norm_x,
  input  wire logic signed [15:0] in_norm_y,
  input  wire logic signed [15:0] in_norm_z,
  output logic                    out_strobe,
  output logic [15:0]             out_reflectance,
  output logic                    out_total_reflection,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_wdata
);

  localparam int F2    = 2 * VECTOR_FRAC_BITS;
  localparam int DOT_W = (F2 + 2 > 34) ? F2 + 2 : 34;
  localparam int SH_R  = (F2 > WORK_FRAC) ? F2 - WORK_FRAC : 0;
  localparam int SH_L  = (F2 > WORK_FRAC) ? 0 : WORK_FRAC - F2;
  localparam int RSH   = (SH_R > 0) ? SH_R - 1 : 0;
  localparam int CW    = DOT_W + SH_L;
  localparam logic signed [DOT_W-1:0] ONE2F = DOT_W'(1) << F2;
  localparam logic [CW-1:0] RND    = (SH_R > 0) ? (CW'(1) << RSH) : CW'(0);
  localparam logic [CW-1:0] CI_MAX = CW'(1) << WORK_FRAC;
  localparam logic [60:0]   ONE60  = 61'd1 << 60;
  localparam int TOTAL_LAT = 8 + 2 * SQRT_LAT + SDIV_LAT + RDIV_LAT;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] nidx;

  logic signed [31:0] px_r, py_r, pz_r;
  logic               vld_a_r;
  side_t              side_b_r;
  logic               vld_b_r;
  logic [60:0]        sq_c_r;
  side_t              side_c_r;
  logic               vld_c_r;
  side_t              sd1_r [SQRT_LAT];
  logic               sq1_vld;
  logic [30:0]        si;
  logic [45:0]        nmul_d_r;
  side_t              side_d_r;
  logic               vld_d_r;
  side_t              sd2_r [SDIV_LAT];
  logic               div_vld;
  logic [WORK_FRAC-1:0] st;
  logic               st_ovf;
  logic [59:0]        stsq_e_r;
  side_t              side_e_r;
  logic               vld_e_r;
  side_t              sd3_r [SQRT_LAT];
  logic               sq2_vld;
  logic [30:0]        ct;
  logic [45:0]        p1_f_r, q1_f_r, p2_f_r, q2_f_r;
  logic               tir_f_r;
  logic               vld_f_r;
  logic [RDIV_LAT-1:0] tir_g_r;
  logic               rd1_vld, rd2_vld;
  logic [16:0]        r1, r2;
  logic [33:0]        r1sq_h_r, r2sq_h_r;
  logic               tir_h_r;
  logic               vld_h_r;

  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] dotc;
  logic [CW-1:0]           ciw;
  side_t                   side_b_nxt;
  logic [34:0]             sum;
  logic [16:0]             refl;
  logic [15:0]             refl_nxt;

  assign busy = 1'b0;
  assign nidx = (idx_r == '0) ? IDX_W'(1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_RESET;
    end else if (cfg_we) begin
      idx_r <= cfg_wdata;
    end
  end

  always_comb begin
    dot = DOT_W'(px_r) + DOT_W'(py_r) + DOT_W'(pz_r);
    if (dot > ONE2F) begin
      dotc = ONE2F;
    end else if (dot < -ONE2F) begin
      dotc = -ONE2F;
    end else begin
      dotc = dot;
    end
    side_b_nxt.tir = 1'b0;
    if (dotc < 0) begin
      ciw            = CW'(unsigned'(-dotc));
      side_b_nxt.ei  = ONE_IDX;
      side_b_nxt.et  = nidx;
    end else begin
      ciw            = CW'(unsigned'(dotc));
      side_b_nxt.ei  = nidx;
      side_b_nxt.et  = ONE_IDX;
    end
    ciw = ((ciw + RND) >> SH_R) << SH_L;
    if (ciw > CI_MAX) begin
      ciw = CI_MAX;
    end
    side_b_nxt.ci = ciw[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_h_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      vld_a_r <= start && !busy;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= sq1_vld;
      vld_e_r <= div_vld;
      vld_f_r <= sq2_vld;
      vld_h_r <= rd1_vld && rd2_vld;
      out_strobe <= vld_h_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= in_dir_x * in_norm_x;
    py_r <= in_dir_y * in_norm_y;
    pz_r <= in_dir_z * in_norm_z;
    side_b_r <= side_b_nxt;
    side_c_r <= side_b_r;
    sq_c_r   <= {30'b0, side_b_r.ci} * {30'b0, side_b_r.ci};
    sd1_r[0] <= side_c_r;
    sd2_r[0] <= side_d_r;
    sd3_r[0] <= side_e_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      sd1_r[i] <= sd1_r[i-1];
      sd3_r[i] <= sd3_r[i-1];
    end
    for (int i = 1; i < SDIV_LAT; i++) begin
      sd2_r[i] <= sd2_r[i-1];
    end
    nmul_d_r <= {15'b0, si} * {31'b0, sd1_r[SQRT_LAT-1].ei};
    side_d_r <= sd1_r[SQRT_LAT-1];
    stsq_e_r <= {30'b0, st} * {30'b0, st};
    side_e_r <= {sd2_r[SDIV_LAT-1].ci, sd2_r[SDIV_LAT-1].ei, sd2_r[SDIV_LAT-1].et, st_ovf};
    p1_f_r <= {31'b0, sd3_r[SQRT_LAT-1].et} * {15'b0, sd3_r[SQRT_LAT-1].ci};
    q1_f_r <= {31'b0, sd3_r[SQRT_LAT-1].ei} * {15'b0, ct};
    p2_f_r <= {31'b0, sd3_r[SQRT_LAT-1].ei} * {15'b0, sd3_r[SQRT_LAT-1].ci};
    q2_f_r <= {31'b0, sd3_r[SQRT_LAT-1].et} * {15'b0, ct};
    tir_f_r <= sd3_r[SQRT_LAT-1].tir;
    tir_g_r <= {tir_g_r[RDIV_LAT-2:0], tir_f_r};
    r1sq_h_r <= {17'b0, r1} * {17'b0, r1};
    r2sq_h_r <= {17'b0, r2} * {17'b0, r2};
    tir_h_r  <= tir_g_r[RDIV_LAT-1];
    out_reflectance      <= refl_nxt;
    out_total_reflection <= tir_h_r;
  end

  fdr_sqrt u_sqrt_si (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_c_r),
    .in_rad   (ONE60 - sq_c_r),
    .out_vld  (sq1_vld),
    .out_root (si)
  );

  fdr_sdiv u_sdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_d_r),
    .in_num  (nmul_d_r),
    .in_den  (side_d_r.et),
    .out_vld (div_vld),
    .out_quo (st),
    .out_ovf (st_ovf)
  );

  fdr_sqrt u_sqrt_ct (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_e_r),
    .in_rad   (ONE60 - {1'b0, stsq_e_r}),
    .out_vld  (sq2_vld),
    .out_root (ct)
  );

  fdr_rdiv u_rdiv_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_f_r),
    .in_p      (p1_f_r),
    .in_q      (q1_f_r),
    .out_vld   (rd1_vld),
    .out_ratio (r1)
  );

  fdr_rdiv u_rdiv_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_f_r),
    .in_p      (p2_f_r),
    .in_q      (q2_f_r),
    .out_vld   (rd2_vld),
    .out_ratio (r2)
  );

  always_comb begin
    sum  = {1'b0, r1sq_h_r} + {1'b0, r2sq_h_r} + 35'(1 << 17);
    refl = sum[34:18];
    if (tir_h_r || refl > 17'(REFL_ONE)) begin
      refl_nxt = REFL_ONE;
    end else begin
      refl_nxt = refl[15:0];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL_LAT out_strobe)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without transaction");

  a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_total_reflection) |-> (out_reflectance == REFL_ONE))
    else $error("total reflection with reflectance below one");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_reflectance <= REFL_ONE))
    else $error("reflectance above one");

endmodule
`default_nettype wire

FILE: dv/fresnel_checker.sv
`timescale 1ns / 100ps
module fresnel_checker
  import fdr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic signed [15:0] in_norm_x,
  input  wire logic signed [15:0] in_norm_y,
  input  wire logic signed [15:0] in_norm_z,
  input  wire logic               out_strobe,
  input  wire logic [15:0]        out_reflectance,
  input  wire logic               out_total_reflection,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_wdata,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_reflection;
  } fresnel_t;

  fresnel_t            expected_q[$];
  logic [IDX_W-1:0]    index_model;
  int                  mismatches;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned amp_sq(longint unsigned p, longint unsigned q);
    longint unsigned num, den, r;
    num = (p > q) ? p - q : q - p;
    den = p + q;
    r   = (den == 0) ? 64'd65536 : (num << 16) / den;
    return r * r;
  endfunction

  function automatic fresnel_t predict_fresnel(
    logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] dz,
    logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
    logic [IDX_W-1:0] idx);
    longint          dot, one2f;
    longint unsigned n, ei, et, mag, ci, si, st, ct, sum, refl;
    fresnel_t        res;
    one2f = 64'sd1 << (2 * VECTOR_FRAC_BITS);
    dot = longint'(dx) * longint'(nx) + longint'(dy) * longint'(ny)
        + longint'(dz) * longint'(nz);
    n = (idx == 0) ? 64'd1 : 64'(idx);
    if (dot > one2f) dot = one2f;
    if (dot < -one2f) dot = -one2f;
    if (dot < 0) begin
      mag = 64'(-dot);
      ei  = 64'(ONE_IDX);
      et  = n;
    end else begin
      mag = 64'(dot);
      ei  = n;
      et  = 64'(ONE_IDX);
    end
    if (2 * VECTOR_FRAC_BITS > WORK_FRAC)
      ci = (mag + (64'd1 << (2 * VECTOR_FRAC_BITS - WORK_FRAC - 1)))
           >> (2 * VECTOR_FRAC_BITS - WORK_FRAC);
    else
      ci = mag << (WORK_FRAC - 2 * VECTOR_FRAC_BITS);
    if (ci > (64'd1 << WORK_FRAC)) ci = 64'd1 << WORK_FRAC;
    si = int_sqrt((64'd1 << 60) - ci * ci);
    st = (si * ei) / et;
    if (st >= (64'd1 << WORK_FRAC)) begin
      res.reflectance      = REFL_ONE;
      res.total_reflection = 1'b1;
      return res;
    end
    ct   = int_sqrt((64'd1 << 60) - st * st);
    sum  = amp_sq(et * ci, ei * ct) + amp_sq(ei * ci, et * ct);
    refl = (sum + (64'd1 << 17)) >> 18;
    if (refl > 64'd32768) refl = 64'd32768;
    res.reflectance      = refl[15:0];
    res.total_reflection = 1'b0;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
    index_model = IDX_RESET;
  end

  always @(posedge clk) begin
    fresnel_t want;
    if (!rst_n) begin
      expected_q.delete();
      index_model <= IDX_RESET;
    end else begin
      if (start && !busy)
        expected_q.push_back(predict_fresnel(in_dir_x, in_dir_y, in_dir_z,
                                             in_norm_x, in_norm_y, in_norm_z,
                                             index_model));
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (mismatches < 10)
            $display("unexpected result: reflectance %0d tir %0b",
                     out_reflectance, out_total_reflection);
          mismatches = mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.reflectance !== out_reflectance ||
              want.total_reflection !== out_total_reflection) begin
            fail_count = fail_count + 1;
            if (mismatches < 10)
              $display("mismatch: reflectance exp %0d got %0d, tir exp %0b got %0b",
                       want.reflectance, out_reflectance,
                       want.total_reflection, out_total_reflection);
            mismatches = mismatches + 1;
          end
        end
      end
      if (cfg_we) index_model <= cfg_wdata;
    end
    pending = expected_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import fdr_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [15:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic               out_strobe;
  logic [15:0]        out_reflectance;
  logic               out_total_reflection;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_wdata = '0;
  int                 fail_count;
  int                 pending;

  localparam int DRAIN_CYCLES = 140;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dielectric_fresnel_reflectance dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_norm_z(in_norm_z),
    .out_strobe(out_strobe), .out_reflectance(out_reflectance),
    .out_total_reflection(out_total_reflection),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  fresnel_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_norm_x(in_norm_x), .in_norm_y(in_norm_y), .in_norm_z(in_norm_z),
    .out_strobe(out_strobe), .out_reflectance(out_reflectance),
    .out_total_reflection(out_total_reflection),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send(input logic signed [15:0] dx, dy, dz, nx, ny, nz);
    int g;
    start     <= 1'b1;
    in_dir_x  <= dx;
    in_dir_y  <= dy;
    in_dir_z  <= dz;
    in_norm_x <= nx;
    in_norm_y <= ny;
    in_norm_z <= nz;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic unit_vec(output logic signed [15:0] x, y, z);
    real a, b, c, len, scale;
    do begin
      a = $urandom_range(2000) - 1000.0;
      b = $urandom_range(2000) - 1000.0;
      c = $urandom_range(2000) - 1000.0;
      len = $sqrt(a * a + b * b + c * c);
    end while (len < 1.0);
    scale = (16384.0 + $urandom_range(8) - 4.0) / len;
    x = 16'($rtoi(a * scale));
    y = 16'($rtoi(b * scale));
    z = 16'($rtoi(c * scale));
  endtask

  task automatic send_random();
    logic signed [15:0] dx, dy, dz, nx, ny, nz;
    if ($urandom_range(99) < 70) begin
      unit_vec(dx, dy, dz);
      unit_vec(nx, ny, nz);
    end else begin
      dx = 16'($urandom); dy = 16'($urandom); dz = 16'($urandom);
      nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom);
    end
    send(dx, dy, dz, nx, ny, nz);
  endtask

  task automatic drain_and_write(input logic [IDX_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_set();
    send(0, 0, -16384, 0, 0, 16384);
    send(0, 0, 16384, 0, 0, 16384);
    send(16384, 0, 0, 0, 0, 16384);
    send(11585, 0, 11585, 0, 0, 16384);
    send(11585, 0, -11585, 0, 0, 16384);
    send(-32768, -32768, -32768, -32768, -32768, -32768);
    send(32767, 32767, 32767, 32767, 32767, 32767);
    send(-32768, -32768, -32768, 32767, 32767, 32767);
    send(0, 0, 0, 0, 0, 0);
    send(16384, 0, 0, -16384, 0, 0);
    send(0, 16384, 0, 0, 16384, 0);
    send(1, 0, 0, 1, 0, 0);
    send(-1, 0, 0, 1, 0, 0);
    send(0, 6000, 15246, 0, 0, 16384);
    send(0, 15246, -6000, 0, 0, 16384);
    send(0, -16384, 100, 0, 0, -16384);
  endtask

  logic [IDX_W-1:0] settings [6] = '{15'd4096, 15'd32767, 15'd0, 15'd1, 15'd8192, 15'd6144};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_set();
    repeat (120) send_random();
    foreach (settings[i]) begin
      drain_and_write(settings[i]);
      directed_set();
      repeat (110) send_random();
    end
    drain_and_write(15'($urandom_range(32767, 4096)));
    repeat (150) send_random();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_sqrt.sv
hw/rtl/fdr_sdiv.sv
hw/rtl/fdr_rdiv.sv
hw/rtl/dielectric_fresnel_reflectance.sv
dv/fresnel_checker.sv
dv/tb.sv
